// ===== rtl/ccd_pkg.sv =====
// ----------------------------------------------------------------------------
// ccd_pkg
// Shared types and constants of the clock block cache directory: command
// codes, controller states and the command/status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package ccd_pkg;

  localparam int ENTRIES_DEF    = 64;
  localparam int BLOCK_BITS_DEF = 32;
  localparam int CMD_W          = 2;
  localparam int FIELD_W        = 32;
  localparam int SLOT_W         = 6;
  localparam int COUNT_W        = 7;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOOKUP   = 2'd0,
    CMD_FILL     = 2'd1,
    CMD_WRITE    = 2'd2,
    CMD_SET_SIZE = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOKUP,
    S_SET_SIZE,
    S_HAND_FIX,
    S_SWEEP,
    S_EVICT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic mark_hit;
    logic clear_ge;
    logic hand_fix;
    logic sweep_step;
    logic rd_hand;
    logic fill_wr;
    logic publish;
  } dp_cmd_t;

  typedef struct packed {
    logic match;
    logic scan_done;
    logic hand_used;
    cmd_t cmd;
  } dp_stat_t;

endpackage

// ===== rtl/ccd_ctrl.sv =====
// ----------------------------------------------------------------------------
// ccd_ctrl
// Sequencer of the directory: walks lookup, set size and fill phases and
// drives the datapath, and owns the input and output handshakes.
// ----------------------------------------------------------------------------
module ccd_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  ccd_pkg::cmd_t      in_cmd,
  output logic               out_valid,
  input  logic               out_ready,
  output ccd_pkg::dp_cmd_t   dp_cmd,
  input  ccd_pkg::dp_stat_t  dp_stat
);

  ccd_pkg::state_t state, state_next;
  logic            out_valid_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ccd_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ccd_pkg::S_IDLE: begin
        if (in_valid) begin
          unique case (in_cmd) inside
            ccd_pkg::CMD_LOOKUP,
            ccd_pkg::CMD_WRITE:    state_next = ccd_pkg::S_LOOKUP;
            ccd_pkg::CMD_FILL:     state_next = ccd_pkg::S_HAND_FIX;
            ccd_pkg::CMD_SET_SIZE: state_next = ccd_pkg::S_SET_SIZE;
            default:               state_next = ccd_pkg::S_IDLE;
          endcase
        end
      end
      ccd_pkg::S_LOOKUP: begin
        if (dp_stat.match) begin
          state_next = ccd_pkg::S_DONE;
        end else if (dp_stat.scan_done) begin
          state_next = (dp_stat.cmd == ccd_pkg::CMD_WRITE) ? ccd_pkg::S_HAND_FIX
                                                           : ccd_pkg::S_DONE;
        end
      end
      ccd_pkg::S_SET_SIZE: begin
        if (dp_stat.scan_done) begin
          state_next = ccd_pkg::S_DONE;
        end
      end
      ccd_pkg::S_HAND_FIX: state_next = ccd_pkg::S_SWEEP;
      ccd_pkg::S_SWEEP: begin
        if (!dp_stat.hand_used) begin
          state_next = ccd_pkg::S_EVICT;
        end
      end
      ccd_pkg::S_EVICT: state_next = ccd_pkg::S_DONE;
      ccd_pkg::S_DONE: begin
        if (!out_valid_q || out_ready) begin
          state_next = ccd_pkg::S_IDLE;
        end
      end
      default: state_next = ccd_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    dp_cmd   = '0;
    in_ready = 1'b0;
    unique case (state)
      ccd_pkg::S_IDLE: begin
        in_ready    = 1'b1;
        dp_cmd.load = in_valid;
      end
      ccd_pkg::S_LOOKUP: begin
        dp_cmd.scan     = !dp_stat.match;
        dp_cmd.mark_hit = dp_stat.match;
      end
      ccd_pkg::S_SET_SIZE: begin
        dp_cmd.scan     = 1'b1;
        dp_cmd.clear_ge = 1'b1;
      end
      ccd_pkg::S_HAND_FIX: dp_cmd.hand_fix = 1'b1;
      ccd_pkg::S_SWEEP: begin
        dp_cmd.rd_hand    = 1'b1;
        dp_cmd.sweep_step = dp_stat.hand_used;
      end
      ccd_pkg::S_EVICT: dp_cmd.fill_wr = 1'b1;
      ccd_pkg::S_DONE:  dp_cmd.publish = !out_valid_q || out_ready;
      default: begin
        dp_cmd   = '0;
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid_q <= 1'b0;
    end else if (dp_cmd.publish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid = out_valid_q;

endmodule

// ===== rtl/ccd_datapath.sv =====
// ----------------------------------------------------------------------------
// ccd_datapath
// Entry status flags, block number memory, clock hand, scan counter,
// entry count register and result registers of the directory.
// ----------------------------------------------------------------------------
module ccd_datapath #(
  parameter int ENTRIES    = ccd_pkg::ENTRIES_DEF,
  parameter int BLOCK_BITS = ccd_pkg::BLOCK_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wr_en,
  input  logic [ccd_pkg::COUNT_W-1:0]  cfg_wr_data,
  input  ccd_pkg::cmd_t                in_cmd,
  input  logic [ccd_pkg::FIELD_W-1:0]  in_block_number,
  input  logic [ccd_pkg::FIELD_W-1:0]  in_new_size,
  input  ccd_pkg::dp_cmd_t             dp_cmd,
  output ccd_pkg::dp_stat_t            dp_stat,
  output logic                         hit,
  output logic [ccd_pkg::SLOT_W-1:0]   slot,
  output logic                         slot_valid,
  output logic                         evict_valid,
  output logic [ccd_pkg::FIELD_W-1:0]  evict_block
);

  localparam int IW   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW   = $clog2(ENTRIES + 1);
  localparam int RW   = (CW > ccd_pkg::COUNT_W) ? CW : ccd_pkg::COUNT_W;
  localparam int CMPW = (BLOCK_BITS > ccd_pkg::FIELD_W) ? BLOCK_BITS : ccd_pkg::FIELD_W;

  logic [RW-1:0]                count;
  logic [CW-1:0]                n_act;
  logic [ENTRIES-1:0]           occ;
  logic [ENTRIES-1:0]           used;
  logic [BLOCK_BITS-1:0]        mem [ENTRIES];
  logic [BLOCK_BITS-1:0]        rdata;
  logic [IW-1:0]                raddr;
  logic [IW-1:0]                hand;
  logic [CW-1:0]                hand_p1;
  logic [CW-1:0]                idx;
  logic [IW-1:0]                pidx;
  logic                         pvalid;
  ccd_pkg::cmd_t                cmd_q;
  logic [BLOCK_BITS-1:0]        blk;
  logic [ccd_pkg::FIELD_W-1:0]  size_q;
  logic [CMPW-1:0]              bn_ext;
  logic [CMPW-1:0]              rd_ext;
  logic                         ge;
  logic                         res_hit;
  logic [ccd_pkg::SLOT_W-1:0]   res_slot;
  logic                         res_slot_valid;
  logic                         res_evict_valid;
  logic [ccd_pkg::FIELD_W-1:0]  res_evict_block;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= RW'(ENTRIES);
    end else if (cfg_wr_en) begin
      count <= RW'(cfg_wr_data);
    end
  end

  always_comb begin
    if (count == '0) begin
      n_act = CW'(1);
    end else if (count > RW'(ENTRIES)) begin
      n_act = CW'(ENTRIES);
    end else begin
      n_act = CW'(count);
    end
  end

  assign bn_ext  = CMPW'(in_block_number);
  assign rd_ext  = CMPW'(rdata);
  assign ge      = rd_ext >= CMPW'(size_q);
  assign hand_p1 = CW'(hand) + CW'(1);

  always_comb begin
    if (dp_cmd.rd_hand) begin
      raddr = hand;
    end else if (idx < n_act) begin
      raddr = idx[IW-1:0];
    end else begin
      raddr = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.fill_wr) begin
      mem[hand] <= blk;
    end
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.load) begin
      cmd_q  <= in_cmd;
      blk    <= bn_ext[BLOCK_BITS-1:0];
      size_q <= in_new_size;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx    <= '0;
      pidx   <= '0;
      pvalid <= 1'b0;
    end else if (dp_cmd.load) begin
      idx    <= '0;
      pvalid <= 1'b0;
    end else if (dp_cmd.scan) begin
      if (idx < n_act) begin
        pidx   <= idx[IW-1:0];
        pvalid <= 1'b1;
        idx    <= idx + CW'(1);
      end else begin
        pvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hand <= '0;
    end else if (dp_cmd.hand_fix) begin
      if (CW'(hand) >= n_act) begin
        hand <= '0;
      end
    end else if (dp_cmd.sweep_step) begin
      hand <= (hand_p1 >= n_act) ? '0 : hand_p1[IW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ  <= '0;
      used <= '0;
    end else begin
      if (dp_cmd.mark_hit) begin
        used[pidx] <= 1'b1;
      end
      if (dp_cmd.clear_ge && pvalid && occ[pidx] && ge) begin
        occ[pidx]  <= 1'b0;
        used[pidx] <= 1'b0;
      end
      if (dp_cmd.sweep_step) begin
        used[hand] <= 1'b0;
      end
      if (dp_cmd.fill_wr) begin
        occ[hand]  <= 1'b1;
        used[hand] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.load) begin
      res_hit         <= 1'b0;
      res_slot        <= '0;
      res_slot_valid  <= 1'b0;
      res_evict_valid <= 1'b0;
      res_evict_block <= '0;
    end else if (dp_cmd.mark_hit) begin
      res_hit        <= 1'b1;
      res_slot       <= ccd_pkg::SLOT_W'(pidx);
      res_slot_valid <= 1'b1;
    end else if (dp_cmd.fill_wr) begin
      res_hit         <= 1'b0;
      res_slot        <= ccd_pkg::SLOT_W'(hand);
      res_slot_valid  <= 1'b1;
      res_evict_valid <= occ[hand];
      res_evict_block <= occ[hand] ? rd_ext[ccd_pkg::FIELD_W-1:0] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.publish) begin
      hit         <= res_hit;
      slot        <= res_slot;
      slot_valid  <= res_slot_valid;
      evict_valid <= res_evict_valid;
      evict_block <= res_evict_block;
    end
  end

  assign dp_stat.match     = pvalid && occ[pidx] && (rdata == blk);
  assign dp_stat.scan_done = !pvalid && (idx >= n_act);
  assign dp_stat.hand_used = used[hand];
  assign dp_stat.cmd       = cmd_q;

endmodule

// ===== rtl/clock_block_cache_directory.sv =====
// ----------------------------------------------------------------------------
// clock_block_cache_directory
// Directory of a fully associative write-through block cache with CLOCK
// replacement; one result transaction per command transaction.
// ----------------------------------------------------------------------------
// One command at a time. With n active entries, a lookup or set size walks
// the block memory one entry per cycle through its single registered read
// port (a lookup stops early at the first hit). On a fill the hand clears
// the used entries on its way; a write miss runs the lookup walk and then
// a fill. The next command is taken while a result still waits in the
// output register. Reset clears all entry flags at once.
module clock_block_cache_directory #(
  parameter int ENTRIES    = ccd_pkg::ENTRIES_DEF,
  parameter int BLOCK_BITS = ccd_pkg::BLOCK_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wr_en,
  input  logic [ccd_pkg::COUNT_W-1:0]  cfg_wr_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [ccd_pkg::CMD_W-1:0]    cmd,
  input  logic [ccd_pkg::FIELD_W-1:0]  block_number,
  input  logic [ccd_pkg::FIELD_W-1:0]  new_size,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         hit,
  output logic [ccd_pkg::SLOT_W-1:0]   slot,
  output logic                         slot_valid,
  output logic                         evict_valid,
  output logic [ccd_pkg::FIELD_W-1:0]  evict_block
);

  ccd_pkg::dp_cmd_t  dp_cmd;
  ccd_pkg::dp_stat_t dp_stat;
  ccd_pkg::cmd_t     in_cmd;

  assign in_cmd = ccd_pkg::cmd_t'(cmd);

  ccd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_cmd    (in_cmd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .dp_cmd    (dp_cmd),
    .dp_stat   (dp_stat)
  );

  ccd_datapath #(
    .ENTRIES    (ENTRIES),
    .BLOCK_BITS (BLOCK_BITS)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_cmd          (in_cmd),
    .in_block_number (block_number),
    .in_new_size     (new_size),
    .dp_cmd          (dp_cmd),
    .dp_stat         (dp_stat),
    .hit             (hit),
    .slot            (slot),
    .slot_valid      (slot_valid),
    .evict_valid     (evict_valid),
    .evict_block     (evict_block)
  );

`ifndef SYNTH
  a_hit_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && hit |-> slot_valid && !evict_valid)
    else $error("hit result without slot or with eviction");

  a_evict_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && evict_valid |-> slot_valid && !hit)
    else $error("eviction result without filled slot");

  a_evict_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !evict_valid |-> evict_block == '0)
    else $error("evict block nonzero without eviction");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second transaction taken while busy");
`endif

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the clock block cache directory. A directed table
// covers empty-directory misses, duplicate fills, write hits and misses,
// set-size invalidation and entry counts at and beyond their limits. Random
// phases follow, each at its own entry count, with block numbers drawn from a
// small pool so that hits, sweeps and evictions are frequent. A shadow copy of
// the directory predicts all unfixed responses; both handshakes idle at random.
// ----------------------------------------------------------------------------
module tb_top;
  import ccd_pkg::*;

  typedef enum logic [1:0] {
    ENT_EMPTY  = 2'd0,
    ENT_UNUSED = 2'd1,
    ENT_USED   = 2'd2
  } entry_state_t;

  typedef struct packed {
    logic                hit;
    logic [SLOT_W-1:0]   slot;
    logic                slot_valid;
    logic                evict_valid;
    logic [FIELD_W-1:0]  evict_block;
  } dir_resp_t;

  typedef struct {
    bit                  is_cfg;
    logic [COUNT_W-1:0]  count_value;
    cmd_t                op;
    logic [FIELD_W-1:0]  blk;
    logic [FIELD_W-1:0]  size;
    bit                  fixed;
    dir_resp_t           want;
  } stim_row_t;

  localparam int NUM_ENTRIES = ENTRIES_DEF;
  localparam int PHASES      = 14;
  localparam int PHASE_ITEMS = 106;

  logic                clk;
  logic                rst;
  logic                cfg_wr_en;
  logic [COUNT_W-1:0]  cfg_wr_data;
  logic                in_valid;
  logic                in_ready;
  logic [CMD_W-1:0]    cmd;
  logic [FIELD_W-1:0]  block_number;
  logic [FIELD_W-1:0]  new_size;
  logic                out_valid;
  logic                out_ready;
  logic                hit;
  logic [SLOT_W-1:0]   slot;
  logic                slot_valid;
  logic                evict_valid;
  logic [FIELD_W-1:0]  evict_block;

  entry_state_t        shadow_state [NUM_ENTRIES];
  logic [FIELD_W-1:0]  shadow_block [NUM_ENTRIES];
  int                  shadow_hand;
  logic [COUNT_W-1:0]  shadow_count;

  dir_resp_t           dir_resp_q [$];
  stim_row_t           directed_q [$];
  dir_resp_t           got_resp;
  logic [FIELD_W-1:0]  block_pool [16];
  int                  pool_n;
  int                  fail_count;
  int                  rx_hold;
  bit                  tx_calm;
  bit                  rx_calm;

  clock_block_cache_directory uut (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .cmd          (cmd),
    .block_number (block_number),
    .new_size     (new_size),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .hit          (hit),
    .slot         (slot),
    .slot_valid   (slot_valid),
    .evict_valid  (evict_valid),
    .evict_block  (evict_block)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  function automatic int active_entries();
    int n;
    n = int'(shadow_count);
    if (n == 0) n = 1;
    if (n > NUM_ENTRIES) n = NUM_ENTRIES;
    return n;
  endfunction

  function automatic dir_resp_t directory_predict(cmd_t op, logic [FIELD_W-1:0] blk,
                                                  logic [FIELD_W-1:0] size);
    dir_resp_t r;
    int n;
    int idx;
    int g;
    int i;
    r = '0;
    n = active_entries();
    idx = -1;
    if (op == CMD_LOOKUP || op == CMD_WRITE) begin
      for (i = n - 1; i >= 0; i--) begin
        if (shadow_state[i] != ENT_EMPTY && shadow_block[i] == blk) idx = i;
      end
      if (idx >= 0) begin
        shadow_state[idx] = ENT_USED;
        r.hit = 1'b1;
        r.slot = SLOT_W'(idx);
        r.slot_valid = 1'b1;
      end
    end
    if (op == CMD_FILL || (op == CMD_WRITE && idx < 0)) begin
      if (shadow_hand >= n) shadow_hand = 0;
      g = 0;
      while (g < 2 * n + 1 && shadow_state[shadow_hand] == ENT_USED) begin
        shadow_state[shadow_hand] = ENT_UNUSED;
        shadow_hand = (shadow_hand + 1 >= n) ? 0 : shadow_hand + 1;
        g++;
      end
      if (shadow_state[shadow_hand] != ENT_EMPTY) begin
        r.evict_valid = 1'b1;
        r.evict_block = shadow_block[shadow_hand];
      end
      shadow_state[shadow_hand] = ENT_USED;
      shadow_block[shadow_hand] = blk;
      r.slot = SLOT_W'(shadow_hand);
      r.slot_valid = 1'b1;
    end
    if (op == CMD_SET_SIZE) begin
      for (i = 0; i < n; i++) begin
        if (shadow_state[i] != ENT_EMPTY && shadow_block[i] >= size) shadow_state[i] = ENT_EMPTY;
      end
    end
    return r;
  endfunction

  function automatic int pick_gap(bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic stim_row_t op_row(cmd_t op, logic [FIELD_W-1:0] blk,
                                       logic [FIELD_W-1:0] size);
    stim_row_t s;
    s.is_cfg = 1'b0;
    s.count_value = '0;
    s.op = op;
    s.blk = blk;
    s.size = size;
    s.fixed = 1'b0;
    s.want = '0;
    return s;
  endfunction

  function automatic stim_row_t fixed_row(cmd_t op, logic [FIELD_W-1:0] blk,
                                          logic [FIELD_W-1:0] size, logic h,
                                          logic [SLOT_W-1:0] sl, logic sv, logic ev,
                                          logic [FIELD_W-1:0] eb);
    stim_row_t s;
    s = op_row(op, blk, size);
    s.fixed = 1'b1;
    s.want.hit = h;
    s.want.slot = sl;
    s.want.slot_valid = sv;
    s.want.evict_valid = ev;
    s.want.evict_block = eb;
    return s;
  endfunction

  function automatic stim_row_t cfg_row(logic [COUNT_W-1:0] value);
    stim_row_t s;
    s = op_row(CMD_LOOKUP, '0, '0);
    s.is_cfg = 1'b1;
    s.count_value = value;
    return s;
  endfunction

  task automatic issue_command(cmd_t op, logic [FIELD_W-1:0] blk, logic [FIELD_W-1:0] size,
                               bit fixed, dir_resp_t want);
    int gap;
    dir_resp_t pred;
    gap = pick_gap(tx_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd <= op;
    block_number <= blk;
    new_size <= size;
    do @(posedge clk); while (!in_ready);
    pred = directory_predict(op, blk, size);
    dir_resp_q.push_back(fixed ? want : pred);
  endtask

  task automatic drain_responses();
    in_valid <= 1'b0;
    while (dir_resp_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_entry_count(logic [COUNT_W-1:0] value);
    drain_responses();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    shadow_count = value;
  endtask

  task automatic refresh_pool();
    int i;
    int sel;
    pool_n = $urandom_range(2, 16);
    for (i = 0; i < 16; i++) begin
      sel = $urandom_range(0, 2);
      if (sel == 0) block_pool[i] = $urandom_range(0, 31);
      else if (sel == 1) block_pool[i] = $urandom;
      else block_pool[i] = 32'hFFFF_FFFF - $urandom_range(0, 31);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      rx_hold = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (dir_resp_q.size() == 0) begin
          $error("response transaction with no command outstanding");
          fail_count++;
        end else begin
          got_resp = dir_resp_q.pop_front();
          if (hit !== got_resp.hit) begin
            $error("hit: expected %0d, actual %0d", got_resp.hit, hit);
            fail_count++;
          end
          if (slot !== got_resp.slot) begin
            $error("slot: expected %0d, actual %0d", got_resp.slot, slot);
            fail_count++;
          end
          if (slot_valid !== got_resp.slot_valid) begin
            $error("slot_valid: expected %0d, actual %0d", got_resp.slot_valid, slot_valid);
            fail_count++;
          end
          if (evict_valid !== got_resp.evict_valid) begin
            $error("evict_valid: expected %0d, actual %0d", got_resp.evict_valid, evict_valid);
            fail_count++;
          end
          if (evict_block !== got_resp.evict_block) begin
            $error("evict_block: expected %h, actual %h", got_resp.evict_block, evict_block);
            fail_count++;
          end
        end
      end
      if (rx_hold > 0) begin
        rx_hold--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (!rx_calm && $urandom_range(0, 3) == 0) rx_hold = pick_gap(1'b0);
      end
    end
  end

  initial begin
    #3_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin
    int i;
    int k;
    int r;
    int cfg_sel;
    cmd_t op;
    logic [FIELD_W-1:0] blk;
    logic [FIELD_W-1:0] size;
    logic [COUNT_W-1:0] count_value;
    stim_row_t row;

    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_valid = 1'b0;
    cmd = CMD_LOOKUP;
    block_number = '0;
    new_size = '0;
    out_ready = 1'b0;
    fail_count = 0;
    tx_calm = 1'b0;
    rx_calm = 1'b0;
    for (i = 0; i < NUM_ENTRIES; i++) begin
      shadow_state[i] = ENT_EMPTY;
      shadow_block[i] = '0;
    end
    shadow_hand = 0;
    shadow_count = COUNT_W'(NUM_ENTRIES);

    directed_q.push_back(fixed_row(CMD_LOOKUP, 32'h0, 32'h0, 0, 0, 0, 0, 32'h0));
    directed_q.push_back(fixed_row(CMD_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0, 0, 32'h0));
    directed_q.push_back(fixed_row(CMD_FILL, 32'h0, 32'h0, 0, 0, 1, 0, 32'h0));
    directed_q.push_back(op_row(CMD_WRITE, 32'hFFFF_FFFF, 32'h0));
    directed_q.push_back(op_row(CMD_WRITE, 32'hFFFF_FFFF, 32'h0));
    directed_q.push_back(op_row(CMD_LOOKUP, 32'h0, 32'h0));
    directed_q.push_back(op_row(CMD_FILL, 32'h0, 32'h0));
    directed_q.push_back(op_row(CMD_LOOKUP, 32'h0, 32'h0));
    directed_q.push_back(op_row(CMD_FILL, 32'hAAAA_AAAA, 32'h5555_5555));
    directed_q.push_back(op_row(CMD_FILL, 32'h5555_5555, 32'hAAAA_AAAA));
    directed_q.push_back(fixed_row(CMD_SET_SIZE, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                   0, 0, 0, 0, 32'h0));
    directed_q.push_back(fixed_row(CMD_LOOKUP, 32'hFFFF_FFFF, 32'h0, 0, 0, 0, 0, 32'h0));
    directed_q.push_back(fixed_row(CMD_SET_SIZE, 32'h0, 32'h8000_0000, 0, 0, 0, 0, 32'h0));
    directed_q.push_back(fixed_row(CMD_SET_SIZE, 32'hFFFF_FFFF, 32'h0, 0, 0, 0, 0, 32'h0));
    directed_q.push_back(fixed_row(CMD_LOOKUP, 32'h0, 32'h0, 0, 0, 0, 0, 32'h0));
    directed_q.push_back(cfg_row(7'd1));
    directed_q.push_back(fixed_row(CMD_FILL, 32'd5, 32'h0, 0, 0, 1, 0, 32'h0));
    directed_q.push_back(fixed_row(CMD_FILL, 32'd6, 32'h0, 0, 0, 1, 1, 32'd5));
    directed_q.push_back(cfg_row(7'd0));
    directed_q.push_back(fixed_row(CMD_WRITE, 32'd7, 32'h0, 0, 0, 1, 1, 32'd6));
    directed_q.push_back(cfg_row(7'd127));
    directed_q.push_back(op_row(CMD_LOOKUP, 32'd7, 32'h0));
    directed_q.push_back(op_row(CMD_FILL, 32'd8, 32'h0));
    directed_q.push_back(op_row(CMD_FILL, 32'd9, 32'h0));
    directed_q.push_back(op_row(CMD_WRITE, 32'd10, 32'h0));
    directed_q.push_back(cfg_row(7'd2));
    directed_q.push_back(op_row(CMD_FILL, 32'd11, 32'h0));
    directed_q.push_back(op_row(CMD_LOOKUP, 32'd10, 32'h0));
    directed_q.push_back(cfg_row(7'd64));
    directed_q.push_back(op_row(CMD_LOOKUP, 32'd10, 32'h0));
    directed_q.push_back(op_row(CMD_SET_SIZE, 32'h0, 32'd10));
    directed_q.push_back(op_row(CMD_WRITE, 32'd9, 32'h0));

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_q[i]) begin
      row = directed_q[i];
      if (row.is_cfg) write_entry_count(row.count_value);
      else issue_command(row.op, row.blk, row.size, row.fixed, row.want);
    end

    for (k = 0; k < PHASES; k++) begin
      case (k)
        0:       count_value = 7'd64;
        1:       count_value = 7'd1;
        2:       count_value = 7'd0;
        3:       count_value = 7'd127;
        4:       count_value = 7'd65;
        default: begin
          cfg_sel = $urandom_range(0, 9);
          if (cfg_sel < 6) count_value = COUNT_W'($urandom_range(1, 8));
          else if (cfg_sel < 9) count_value = COUNT_W'($urandom_range(1, 64));
          else count_value = COUNT_W'($urandom_range(0, 127));
        end
      endcase
      write_entry_count(count_value);
      tx_calm = ($urandom_range(0, 3) == 0);
      rx_calm = ($urandom_range(0, 3) == 0);
      refresh_pool();
      for (i = 0; i < PHASE_ITEMS; i++) begin
        if ($urandom_range(0, 49) == 0) refresh_pool();
        r = $urandom_range(0, 99);
        op = (r < 35) ? CMD_LOOKUP : (r < 55) ? CMD_FILL : (r < 94) ? CMD_WRITE : CMD_SET_SIZE;
        blk = ($urandom_range(0, 9) == 0) ? $urandom : block_pool[$urandom_range(0, pool_n - 1)];
        case ($urandom_range(0, 5))
          0:       size = $urandom;
          1:       size = 32'h0;
          2:       size = 32'hFFFF_FFFF;
          default: size = block_pool[$urandom_range(0, pool_n - 1)] + $urandom_range(0, 1);
        endcase
        issue_command(op, blk, size, 1'b0, '0);
      end
    end

    drain_responses();
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
